### hdl/sector_record_checker_core_defines.svh
// Assertion macros used by the checker file of the sector record checker.
`ifndef SECTOR_RECORD_CHECKER_CORE_DEFINES_SVH
`define SECTOR_RECORD_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define SRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/src_pkg.sv
// Package of the sector record checker: codes, constants and the bit reversal.
package src_pkg;

  // Status codes carried with the result
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_HDR_FAIL = 2'd1,
    STATUS_SUM_FAIL = 2'd2
  } status_e;

  // Byte position held while no record is in progress
  localparam logic [7:0] POS_IDLE = 8'd255;
  // Header positions
  localparam logic [7:0] POS_TRACK  = 8'd0;
  localparam logic [7:0] POS_SECTOR = 8'd1;
  localparam logic [7:0] POS_HDRSUM = 8'd2;
  // First data position and index of the byte left out of the sum
  localparam int unsigned DATA_BASE  = 3;
  localparam int unsigned SKIP_INDEX = 17;
  // Sectors that leave one data byte out of the checksum
  localparam logic [7:0] SECTOR_SPECIAL_A = 8'd0;
  localparam logic [7:0] SECTOR_SPECIAL_B = 8'd8;

  // Output tdata width: 25 field bits padded to whole bytes
  localparam int unsigned OUT_DATA_W = 32;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

### hdl/sector_record_checker_core.sv
// Sector record checker: header and data checksum check over a byte stream.
// The result of an accepted input transaction appears on the master side in the next cycle.
// Throughput: one byte per cycle; the single output register decouples the two sides,
// so a new byte is taken whenever the result register is empty or being drained.
// Reset (rst_ni low, asynchronous): position 0, all latched record bytes and sums zero,
// no result pending.
module sector_record_checker_core #(
  parameter int unsigned DATA_LENGTH = 151
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] raw_byte
  input  logic        s_axis_tuser_i,  // [0] record_start
  // Master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [14:8] track_number, [22:15] sector_number,
  // [24:23] status_code, [31:25] zero
  output logic [src_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,  // record_done
  output logic        m_axis_tuser_o   // [0] is_payload
);

  // Last data position (checksum byte) and position of the skipped byte
  localparam logic [7:0] POS_LAST = 8'(src_pkg::DATA_BASE + DATA_LENGTH - 1);
  localparam logic [7:0] POS_SKIP = 8'(src_pkg::DATA_BASE + src_pkg::SKIP_INDEX);

  // Record state
  logic [7:0] pos_q, pos_d;
  logic [7:0] track_q, track_d;
  logic [7:0] sector_q, sector_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] skip_q, skip_d;
  logic       rej_q, rej_d;

  // Result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_payload_q;
  logic        out_done_q;
  logic [6:0]  out_track_q;
  logic [7:0]  out_sector_q;
  src_pkg::status_e out_status_q;

  // Combinational step results
  logic [7:0] rev_byte;
  logic [7:0] pos_cur;
  logic [7:0] hdr_sum;
  logic [7:0] wanted;
  logic       special;
  logic       payload;
  logic       done;
  src_pkg::status_e status;
  logic       s_fire;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // One record step per byte
  always_comb begin
    rev_byte = src_pkg::reverse8(s_axis_tdata_i);
    pos_cur  = s_axis_tuser_i ? src_pkg::POS_TRACK : pos_q;
    rej_d    = s_axis_tuser_i ? 1'b0 : rej_q;
    sum_d    = s_axis_tuser_i ? 8'd0 : sum_q;
    skip_d   = s_axis_tuser_i ? 8'd0 : skip_q;
    pos_d    = pos_cur;
    track_d  = track_q;
    sector_d = sector_q;
    hdr_sum  = track_q + sector_q;
    special  = (sector_q == src_pkg::SECTOR_SPECIAL_A) ||
               (sector_q == src_pkg::SECTOR_SPECIAL_B);
    wanted   = special ? (rev_byte + skip_d) : rev_byte;
    payload  = 1'b0;
    done     = 1'b0;
    status   = src_pkg::STATUS_OK;
    if (pos_cur != src_pkg::POS_IDLE && !rej_d) begin
      if (pos_cur == src_pkg::POS_TRACK) begin
        track_d = rev_byte;
        pos_d   = src_pkg::POS_SECTOR;
      end else if (pos_cur == src_pkg::POS_SECTOR) begin
        sector_d = rev_byte;
        pos_d    = src_pkg::POS_HDRSUM;
      end else if (pos_cur == src_pkg::POS_HDRSUM) begin
        if (hdr_sum != rev_byte) begin
          rej_d  = 1'b1;
          done   = 1'b1;
          status = src_pkg::STATUS_HDR_FAIL;
          pos_d  = src_pkg::POS_IDLE;
        end else begin
          pos_d = pos_cur + 8'd1;
        end
      end else begin
        payload = 1'b1;
        if (pos_cur < POS_LAST) begin
          // Data byte: accumulate, or park the skipped byte
          if (special && pos_cur == POS_SKIP) begin
            skip_d = rev_byte;
          end else begin
            sum_d = sum_d + rev_byte;
          end
          pos_d = pos_cur + 8'd1;
        end else begin
          // Checksum byte closes the record
          done   = 1'b1;
          status = (wanted == sum_d) ? src_pkg::STATUS_OK : src_pkg::STATUS_SUM_FAIL;
          pos_d  = src_pkg::POS_IDLE;
        end
      end
    end
  end

  // Record state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= src_pkg::POS_TRACK;
      track_q  <= 8'd0;
      sector_q <= 8'd0;
      sum_q    <= 8'd0;
      skip_q   <= 8'd0;
      rej_q    <= 1'b0;
    end else if (s_fire) begin
      pos_q    <= pos_d;
      track_q  <= track_d;
      sector_q <= sector_d;
      sum_q    <= sum_d;
      skip_q   <= skip_d;
      rej_q    <= rej_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_byte_q    <= rev_byte;
      out_payload_q <= payload;
      out_done_q    <= done;
      out_track_q   <= track_d[7:1];
      out_sector_q  <= sector_d;
      out_status_q  <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_status_q, out_sector_q, out_track_q, out_byte_q};
  assign m_axis_tlast_o  = out_done_q;
  assign m_axis_tuser_o  = out_payload_q;

endmodule

### hdl/src_checker.sv
// Port-level checker for the sector record checker and its bind.
`include "sector_record_checker_core_defines.svh"

module src_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,  // [7:0] raw_byte
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [src_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // see top level
  input logic        m_axis_tlast_o,  // record_done
  input logic        m_axis_tuser_o   // [0] is_payload
);

  logic [1:0] status;
  logic       stalled;
  logic       in_fire;

  assign status  = m_axis_tdata_o[24:23];
  assign stalled = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // A nonzero status only comes with the end of a record
  `SRC_ASSERT_IMPLY(a_status_needs_done, clk_i, rst_ni,
    m_axis_tvalid_o && status != src_pkg::STATUS_OK, m_axis_tlast_o)

  // A header rejection is never part of the data field, and code 3 is never sent
  `SRC_ASSERT_IMPLY(a_hdr_fail_no_payload, clk_i, rst_ni,
    m_axis_tvalid_o && status != src_pkg::STATUS_SUM_FAIL && status != src_pkg::STATUS_OK,
    status == src_pkg::STATUS_HDR_FAIL && !m_axis_tuser_o)

  // Each accepted byte yields a result next cycle; its end bits show the byte reversed in the low bits
  `SRC_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni,
    in_fire, m_axis_tvalid_o && m_axis_tdata_o[0] == $past(s_axis_tdata_i[7]) &&
    m_axis_tdata_o[7] == $past(s_axis_tdata_i[0]))

  // A stalled result holds
  `SRC_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    stalled, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

endmodule

bind sector_record_checker_core src_checker u_src_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### tb/sv/sector_record_checker_core_tb.sv
// Self-checking testbench for the sector record checker core.
module sector_record_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_LEN = 151;
  localparam int unsigned REC_LEN  = src_pkg::DATA_BASE + DATA_LEN;

  // One expected result, as the block reports it
  typedef struct packed {
    logic [7:0]       data;
    logic             payload;
    logic             done;
    logic [6:0]       track;
    logic [7:0]       sector;
    src_pkg::status_e status;
  } sector_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [src_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  // Predictor state
  logic [7:0] rec_pos;
  logic [7:0] hdr_track;
  logic [7:0] hdr_sector;
  logic [7:0] data_sum;
  logic [7:0] held_byte;
  logic       rec_rejected;

  sector_result_t expected_q[$];
  int unsigned    errors;
  int unsigned    bytes_sent;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;

  sector_record_checker_core #(
    .DATA_LENGTH(DATA_LEN)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2ms;
    $display("[sector_record_checker_core] ERROR");
    $finish;
  end

  // Advance the predictor by one accepted byte and queue the expected result
  function automatic void predict_record_byte(input logic [7:0] raw, input logic start);
    logic [7:0]     b;
    logic [7:0]     wanted;
    logic           special;
    int unsigned    d;
    sector_result_t r;
    b = {<<{raw}};
    r = '0;
    if (start) begin
      rec_pos      = src_pkg::POS_TRACK;
      rec_rejected = 1'b0;
      data_sum     = '0;
      held_byte    = '0;
    end
    if (rec_pos != src_pkg::POS_IDLE && !rec_rejected) begin
      if (rec_pos == src_pkg::POS_TRACK) begin
        hdr_track = b;
        rec_pos   = src_pkg::POS_SECTOR;
      end else if (rec_pos == src_pkg::POS_SECTOR) begin
        hdr_sector = b;
        rec_pos    = src_pkg::POS_HDRSUM;
      end else if (rec_pos == src_pkg::POS_HDRSUM) begin
        if (8'(hdr_track + hdr_sector) != b) begin
          rec_rejected = 1'b1;
          r.done       = 1'b1;
          r.status     = src_pkg::STATUS_HDR_FAIL;
          rec_pos      = src_pkg::POS_IDLE;
        end else begin
          rec_pos = 8'(src_pkg::DATA_BASE);
        end
      end else begin
        d         = rec_pos - src_pkg::DATA_BASE;
        special   = (hdr_sector == src_pkg::SECTOR_SPECIAL_A) ||
                    (hdr_sector == src_pkg::SECTOR_SPECIAL_B);
        r.payload = 1'b1;
        if (d < DATA_LEN - 1) begin
          // sectors 0 and 8 hold one byte out of the running sum
          if (special && d == src_pkg::SKIP_INDEX) held_byte = b;
          else data_sum = data_sum + b;
          rec_pos = rec_pos + 8'd1;
        end else begin
          wanted   = special ? 8'(b + held_byte) : b;
          r.done   = 1'b1;
          r.status = (wanted == data_sum) ? src_pkg::STATUS_OK : src_pkg::STATUS_SUM_FAIL;
          rec_pos  = src_pkg::POS_IDLE;
        end
      end
    end
    r.data   = b;
    r.track  = hdr_track[7:1];
    r.sector = hdr_sector;
    expected_q.push_back(r);
  endfunction

  function automatic void report_mismatch(input string field, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    errors++;
  endfunction

  // Compare one output transaction against the oldest expectation
  function automatic void check_result();
    sector_result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got tdata %0h", $time, m_axis_tdata_o);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (m_axis_tdata_o[7:0] !== exp_r.data)
      report_mismatch("data_byte", 32'(exp_r.data), 32'(m_axis_tdata_o[7:0]));
    if (m_axis_tdata_o[14:8] !== exp_r.track)
      report_mismatch("track_number", 32'(exp_r.track), 32'(m_axis_tdata_o[14:8]));
    if (m_axis_tdata_o[22:15] !== exp_r.sector)
      report_mismatch("sector_number", 32'(exp_r.sector), 32'(m_axis_tdata_o[22:15]));
    if (m_axis_tdata_o[24:23] !== exp_r.status)
      report_mismatch("status_code", 32'(exp_r.status), 32'(m_axis_tdata_o[24:23]));
    if (m_axis_tdata_o[src_pkg::OUT_DATA_W-1:25] !== '0)
      report_mismatch("tdata padding", 32'd0,
                      32'(m_axis_tdata_o[src_pkg::OUT_DATA_W-1:25]));
    if (m_axis_tlast_o !== exp_r.done)
      report_mismatch("record_done", 32'(exp_r.done), 32'(m_axis_tlast_o));
    if (m_axis_tuser_o !== exp_r.payload)
      report_mismatch("is_payload", 32'(exp_r.payload), 32'(m_axis_tuser_o));
  endfunction

  // Master side: random stalls and a check on every accepted transaction
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result();
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one byte given as the block sees it after bit reversal; returns at acceptance
  task automatic send_byte(input logic [7:0] value, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {<<{value}};
    s_axis_tuser_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_record_byte({<<{value}}, start);
    bytes_sent++;
  endtask

  // One record: header, data and checksum, cut short after 'cut' bytes
  task automatic send_record(input logic [7:0] trk, input logic [7:0] sec, input bit hdr_ok,
                             input bit sum_ok, input int unsigned cut);
    logic [7:0] rec[$];
    logic [7:0] hdr;
    logic [7:0] sum;
    logic [7:0] held;
    logic [7:0] b;
    logic       special;
    hdr = trk + sec;
    if (!hdr_ok) hdr = hdr + 8'($urandom_range(255, 1));
    special = (sec == src_pkg::SECTOR_SPECIAL_A) || (sec == src_pkg::SECTOR_SPECIAL_B);
    sum = '0;
    held = '0;
    rec.push_back(trk);
    rec.push_back(sec);
    rec.push_back(hdr);
    for (int d = 0; d < DATA_LEN - 1; d++) begin
      b = 8'($urandom);
      if (special && d == src_pkg::SKIP_INDEX) held = b;
      else sum = sum + b;
      rec.push_back(b);
    end
    b = sum - held;
    if (!sum_ok) b = b + 8'($urandom_range(255, 1));
    rec.push_back(b);
    foreach (rec[i]) begin
      if (i < cut) send_byte(rec[i], i == 0);
    end
  endtask

  // Bytes before any start are taken as a record from position 0
  task automatic test_start_free_after_reset();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  // A start in mid-record abandons the record in progress
  task automatic test_restart_mid_record();
    send_byte(8'h10, 1'b1);
    send_byte(8'h08, 1'b0);
    send_byte(8'h18, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // Header sum mismatch, then bytes that must be ignored
  task automatic test_header_reject();
    send_byte(8'hFE, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Extreme header values with a header sum that wraps
  task automatic test_header_wrap();
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h81, 1'b0);
  endtask

  // Records with random content, mostly complete (with good or bad sums), plus broken ones and noise
  task automatic test_random_records(input int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    logic [7:0]  sec;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      if ($urandom_range(99) < 40)
        sec = $urandom_range(1) ? src_pkg::SECTOR_SPECIAL_B : src_pkg::SECTOR_SPECIAL_A;
      else sec = 8'($urandom);
      if (kind < 60) begin
        send_record(8'($urandom), sec, 1'b1, 1'($urandom_range(1)), REC_LEN);
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end else if (kind < 75) begin
        send_record(8'($urandom), sec, 1'b0, 1'b1, $urandom_range(7, 3));
      end else if (kind < 90) begin
        send_record(8'($urandom), sec, 1'b1, 1'b1, $urandom_range(REC_LEN - 1, 1));
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    rst_ni          <= 1'b0;
    rec_pos      = src_pkg::POS_TRACK;
    hdr_track    = '0;
    hdr_sector   = '0;
    data_sum     = '0;
    held_byte    = '0;
    rec_rejected = 1'b0;
    errors       = 0;
    bytes_sent   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_start_free_after_reset();
    test_restart_mid_record();
    test_header_reject();
    test_header_wrap();

    // Random part over the idling phases
    test_random_records(110);
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    test_random_records(110);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    test_random_records(110);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    test_random_records(110);

    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[sector_record_checker_core] OK");
    end else begin
      $display("[sector_record_checker_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/src_pkg.sv
hdl/sector_record_checker_core.sv
hdl/src_checker.sv
tb/sv/sector_record_checker_core_tb.sv
